>>> rtl/core/chss_pkg.sv
`default_nettype none

package chss_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int PIX_W   = 8;
   localparam int CHR_W   = 2 * PIX_W;
   localparam int MODE_W  = 2;
   localparam int FW_W    = 12;
   localparam int FH_W    = 13;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 13;

   localparam logic [CSR_AW-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [MODE_W-1:0] MODE_VPAIR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HPAIR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BLOCK = 2'd2;
   localparam logic [MODE_W-1:0] MODE_VQUAD = 2'd3;

   localparam logic [FW_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd480;

   typedef struct packed {
      logic row_odd;
      logic row_quad;
      logic col_odd;
      logic frame_end;
   } pix_ctl_type;

endpackage

`default_nettype wire

>>> rtl/core/chss_pos.sv
`default_nettype none

module chss_pos
   import chss_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1,
   localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [FW_W-1:0]   frame_width,
   input  wire logic [FH_W-1:0]   frame_height,
   output logic      [CW-1:0]     col,
   output pix_ctl_type            ctl
);

   localparam int WC = (FW_W > CW + 1) ? FW_W : CW + 1;
   localparam int HC = (FH_W > RW + 1) ? FH_W : RW + 1;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [WC-1:0] fw_x, eff_w;
   logic [HC-1:0] fh_x, eff_h;
   logic          last_col, last_row;
   logic [1:0]    row_lo;

   always_comb begin
      fw_x  = WC'(frame_width);
      fh_x  = HC'(frame_height);
      eff_w = (fw_x == '0) ? WC'(1) : ((fw_x > WC'(MAX_WIDTH)) ? WC'(MAX_WIDTH) : fw_x);
      eff_h = (fh_x == '0) ? HC'(1) : ((fh_x > HC'(MAX_HEIGHT)) ? HC'(MAX_HEIGHT) : fh_x);
      last_col = (WC'(col_ff) + WC'(1)) >= eff_w;
      last_row = (HC'(row_ff) + HC'(1)) >= eff_h;
      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign row_lo        = 2'(row_ff);
   assign col           = col_ff;
   assign ctl.row_odd   = row_lo[0];
   assign ctl.row_quad  = (row_lo != 2'd0);
   assign ctl.col_odd   = col_ff[0];
   assign ctl.frame_end = last_col & last_row;

endmodule

`default_nettype wire

>>> rtl/core/chss_line.sv
`default_nettype none

module chss_line
   import chss_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [MODE_W-1:0] mode,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [PIX_W-1:0]  luma_in,
   input  wire logic [CHR_W-1:0]  own_in,
   input  wire logic [CW-1:0]     col,
   input  wire pix_ctl_type       ctl,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [PIX_W-1:0]  luma_out,
   output logic      [CHR_W-1:0]  chroma_out,
   output logic                   frame_end
);

   logic [CHR_W-1:0] line_mem [MAX_WIDTH];

   logic             v1_ff, fwd_ff, v2_ff;
   logic [PIX_W-1:0] luma1_ff, luma2_ff;
   logic [CHR_W-1:0] own1_ff, rd_ff, held_ff, chroma2_ff;
   logic [CW-1:0]    col1_ff;
   pix_ctl_type      ctl1_ff;
   logic             end2_ff;
   logic             accept, go, fwd_in;
   logic [CHR_W-1:0] above, chroma;

   assign go        = v1_ff && (!v2_ff || !rsp_stall);
   assign req_stall = v1_ff && !go;
   assign accept    = req_valid && !req_stall;
   assign fwd_in    = go && (col1_ff == col);

   always_comb begin
      above = fwd_ff ? held_ff : rd_ff;
      unique case (mode)
         MODE_VPAIR: chroma = ctl1_ff.row_odd ? above : own1_ff;
         MODE_HPAIR: chroma = ctl1_ff.col_odd ? held_ff : own1_ff;
         MODE_BLOCK: chroma = ctl1_ff.row_odd ? above :
                              (ctl1_ff.col_odd ? held_ff : own1_ff);
         MODE_VQUAD: chroma = ctl1_ff.row_quad ? above : own1_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (go) line_mem[col1_ff] <= chroma;
   end

   always_ff @(posedge clock) begin
      if (accept) rd_ff <= line_mem[col];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         fwd_ff  <= 1'b0;
         v2_ff   <= 1'b0;
         held_ff <= '0;
      end else begin
         if (accept) begin
            v1_ff  <= 1'b1;
            fwd_ff <= fwd_in;
         end else if (go) begin
            v1_ff  <= 1'b0;
            fwd_ff <= 1'b0;
         end
         if (go) begin
            v2_ff   <= 1'b1;
            held_ff <= chroma;
         end else if (!rsp_stall) begin
            v2_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         luma1_ff <= luma_in;
         own1_ff  <= own_in;
         col1_ff  <= col;
         ctl1_ff  <= ctl;
      end
      if (go) begin
         luma2_ff   <= luma1_ff;
         chroma2_ff <= chroma;
         end2_ff    <= ctl1_ff.frame_end;
      end
   end

   assign rsp_valid  = v2_ff;
   assign luma_out   = luma2_ff;
   assign chroma_out = chroma2_ff;
   assign frame_end  = end2_ff;

   a_fwd_needs_item: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> v1_ff)
      else $error("forward flag set with empty stage");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !go) |=> ($stable(rd_ff) && $stable(col1_ff) && $stable(fwd_ff)))
      else $error("stalled stage changed");

   a_held_matches_out: assert property (@(posedge clock) disable iff (reset)
      go |=> (held_ff == chroma_out))
      else $error("hold register differs from delivered chroma");

endmodule

`default_nettype wire

>>> rtl/core/chroma_subsample_replicate.sv
`default_nettype none

// channel | ports                                   | accepted when
// req     | req_valid req_stall req_luma/cr/cb_in   | req_valid && !req_stall
// rsp     | rsp_valid rsp_stall rsp_*_out frame_end | rsp_valid && !rsp_stall
// csr     | csr_write csr_index csr_data            | csr_write
//
// One pixel per cycle sustained while rsp_stall is low; the response is registered.
// The line buffer is a single-port-read, single-port-write RAM read at accept and written
// as the input stage advances; a same-column read is forwarded from the hold register.
// Reset clears counters, hold register, config and valids; the line buffer is not cleared.
// A response stall holds the output register and backs up into req_stall.

module chroma_subsample_replicate
   import chss_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [PIX_W-1:0]  req_luma_in,
   input  wire logic [PIX_W-1:0]  req_cr_in,
   input  wire logic [PIX_W-1:0]  req_cb_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [PIX_W-1:0]  rsp_luma_out,
   output logic      [PIX_W-1:0]  rsp_cr_out,
   output logic      [PIX_W-1:0]  rsp_cb_out,
   output logic                   rsp_frame_end,
   input  wire logic              csr_write,
   input  wire logic [CSR_AW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_data
);

   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

   logic [MODE_W-1:0] mode_ff;
   logic [FW_W-1:0]   width_ff;
   logic [FH_W-1:0]   height_ff;
   logic [CW-1:0]     col;
   pix_ctl_type       ctl;
   logic [CHR_W-1:0]  chroma_out;
   logic              step;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_VPAIR;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:   mode_ff   <= csr_data[MODE_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_data[FW_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data[FH_W-1:0];
            default: ;
         endcase
      end
   end

   assign step = req_valid && !req_stall;

   chss_pos #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pos (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .col          (col),
      .ctl          (ctl)
   );

   chss_line #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .luma_in    (req_luma_in),
      .own_in     ({req_cr_in, req_cb_in}),
      .col        (col),
      .ctl        (ctl),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .luma_out   (rsp_luma_out),
      .chroma_out (chroma_out),
      .frame_end  (rsp_frame_end)
   );

   assign rsp_cr_out = chroma_out[CHR_W-1:PIX_W];
   assign rsp_cb_out = chroma_out[PIX_W-1:0];

endmodule

`default_nettype wire

>>> tb/chroma_check.sv
module chroma_check
   import chss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [PIX_W-1:0]  req_luma_in,
   input  wire logic [PIX_W-1:0]  req_cr_in,
   input  wire logic [PIX_W-1:0]  req_cb_in,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [PIX_W-1:0]  rsp_luma_out,
   input  wire logic [PIX_W-1:0]  rsp_cr_out,
   input  wire logic [PIX_W-1:0]  rsp_cb_out,
   input  wire logic              rsp_frame_end,
   input  wire logic              csr_write,
   input  wire logic [CSR_AW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_data,
   output int                     mismatches,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] cr;
      logic [PIX_W-1:0] cb;
      logic             frame_end;
   } pixel_type;

   pixel_type         expected_pixels[$];
   logic [MODE_W-1:0] mode_q;
   logic [FW_W-1:0]   width_q;
   logic [FH_W-1:0]   height_q;
   int unsigned       col_q;
   int unsigned       row_q;
   logic [CHR_W-1:0]  left_chroma;
   logic [CHR_W-1:0]  line_chroma [MAX_WIDTH_DEF];

   function automatic int unsigned clamp_size(int unsigned size, int unsigned limit);
      if (size == 0) return 1;
      return (size > limit) ? limit : size;
   endfunction

   task automatic predict_pixel(input logic [PIX_W-1:0] y, cr, cb);
      int unsigned      w;
      int unsigned      h;
      logic [CHR_W-1:0] above;
      logic [CHR_W-1:0] chroma;
      pixel_type        px;
      w = clamp_size(32'(width_q), MAX_WIDTH_DEF);
      h = clamp_size(32'(height_q), MAX_HEIGHT_DEF);
      above = line_chroma[col_q];
      chroma = {cr, cb};
      case (mode_q)
         MODE_VPAIR: begin
            if (row_q % 2 != 0) chroma = above;
         end
         MODE_HPAIR: begin
            if (col_q % 2 != 0) chroma = left_chroma;
         end
         MODE_BLOCK: begin
            if (row_q % 2 != 0) chroma = above;
            else if (col_q % 2 != 0) chroma = left_chroma;
         end
         default: begin
            if (row_q % 4 != 0) chroma = above;
         end
      endcase
      line_chroma[col_q] = chroma;
      left_chroma = chroma;
      px.luma = y;
      px.cr = chroma[CHR_W-1:PIX_W];
      px.cb = chroma[PIX_W-1:0];
      px.frame_end = (col_q + 1 >= w) && (row_q + 1 >= h);
      if (col_q + 1 >= w) begin
         col_q = 0;
         row_q = (row_q + 1 >= h) ? 0 : row_q + 1;
      end else begin
         col_q = col_q + 1;
      end
      expected_pixels.push_back(px);
   endtask

   always @(posedge clock) begin : monitor
      pixel_type want;
      pixel_type got;
      if (reset) begin
         mode_q = MODE_VPAIR;
         width_q = WIDTH_RESET;
         height_q = HEIGHT_RESET;
         col_q = 0;
         row_q = 0;
         left_chroma = '0;
         mismatches = 0;
         expected_pixels.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MODE:   mode_q = csr_data[MODE_W-1:0];
               CSR_WIDTH:  width_q = csr_data[FW_W-1:0];
               CSR_HEIGHT: height_q = csr_data[FH_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_pixel(req_luma_in, req_cr_in, req_cb_in);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_luma_out, rsp_cr_out, rsp_cb_out, rsp_frame_end};
            if (expected_pixels.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t unexpected transaction: luma %0d cr %0d cb %0d end %0b",
                           $realtime, got.luma, got.cr, got.cb, got.frame_end);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (want !== got) begin
                  if (mismatches < 10)
                     $display({"%0t mismatch: expected luma %0d cr %0d cb %0d end %0b,",
                               " got luma %0d cr %0d cb %0d end %0b"},
                              $realtime, want.luma, want.cr, want.cb, want.frame_end,
                              got.luma, got.cr, got.cb, got.frame_end);
                  mismatches++;
               end
            end
         end
      end
      outstanding = expected_pixels.size();
   end

endmodule

>>> tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import chss_pkg::*;

   localparam logic [CSR_AW-1:0] CSR_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 1720;
   localparam int FILL_COLS    = 64;
   localparam int CYCLE_LIMIT  = 500000;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [PIX_W-1:0]  req_luma_in = '0;
   logic [PIX_W-1:0]  req_cr_in = '0;
   logic [PIX_W-1:0]  req_cb_in = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [PIX_W-1:0]  rsp_luma_out;
   logic [PIX_W-1:0]  rsp_cr_out;
   logic [PIX_W-1:0]  rsp_cb_out;
   logic              rsp_frame_end;
   logic              csr_write = 1'b0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_data = '0;

   int mismatches;
   int outstanding;
   int random_items = 0;
   int directed_index = 0;
   bit calm = 1'b0;
   bit quiet = 1'b0;

   chroma_subsample_replicate dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_luma_in(req_luma_in), .req_cr_in(req_cr_in), .req_cb_in(req_cb_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_luma_out(rsp_luma_out), .rsp_cr_out(rsp_cr_out), .rsp_cb_out(rsp_cb_out),
      .rsp_frame_end(rsp_frame_end),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   chroma_check pixel_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_luma_in(req_luma_in), .req_cr_in(req_cr_in), .req_cb_in(req_cb_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_luma_out(rsp_luma_out), .rsp_cr_out(rsp_cr_out), .rsp_cb_out(rsp_cb_out),
      .rsp_frame_end(rsp_frame_end),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin : stall_gen
      int left;
      left = 0;
      forever begin
         @(negedge clock);
         if (left > 0) left--;
         else if (!calm && !quiet && $urandom_range(0, 9) == 0) left = $urandom_range(1, 15);
         rsp_stall <= (left > 0);
      end
   end

   function automatic logic [PIX_W-1:0] corner(int k);
      case (k % 4)
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h55;
         default: return 8'hAA;
      endcase
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] y, cr, cb);
      int gap;
      if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 15);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_luma_in <= y;
      req_cr_in <= cr;
      req_cb_in <= cb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                 PIX_W'($urandom_range(0, 255)));
   endtask

   // drain the pipe so registers change only while idle
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
   endtask

   task automatic set_regs(input logic [MODE_W-1:0] m, input logic [FW_W-1:0] w,
                           input logic [FH_W-1:0] h, input logic [3:0] sel);
      logic [CSR_DW-1:0] junk;
      junk = CSR_DW'($urandom);
      if (sel[0]) write_csr(CSR_MODE, {junk[CSR_DW-1:MODE_W], m});
      if (sel[1]) write_csr(CSR_WIDTH, {junk[CSR_DW-1], w});
      if (sel[2]) write_csr(CSR_HEIGHT, h);
      if (sel[3]) write_csr(CSR_SPARE, ~junk);
      csr_write <= 1'b0;
   endtask

   task automatic run_directed(input logic [MODE_W-1:0] m, input logic [FW_W-1:0] w,
                               input logic [FH_W-1:0] h, input logic [3:0] sel, input int count);
      settle();
      set_regs(m, w, h, sel);
      repeat (count) begin
         send_pixel(corner(directed_index), corner(directed_index + 1),
                    ~corner(directed_index + 2));
         directed_index++;
      end
   endtask

   initial begin : stimulus
      int                n;
      logic [MODE_W-1:0] m;
      logic [FW_W-1:0]   w;
      logic [FH_W-1:0]   h;
      logic [3:0]        sel;
      logic [MODE_W-1:0] mode_now;
      int                width_now;
      bit                wide_now;
      bit                wide_prev;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // row 0 at reset settings, then fill the first FILL_COLS line buffer entries;
      // frames wider than that run only in horizontal-pair mode
      repeat (4) send_random();
      settle();
      set_regs(MODE_HPAIR, 12'(FILL_COLS), 13'd4, 4'b0111);
      repeat (FILL_COLS - 4) send_random();

      run_directed(MODE_BLOCK, 12'd3, 13'd2, 4'b0111, 6);
      run_directed(MODE_VPAIR, 12'd0, 13'd0, 4'b0111, 2);
      run_directed(MODE_VQUAD, 12'd1, 13'd8191, 4'b0111, 5);
      run_directed(MODE_HPAIR, 12'd4095, 13'd4096, 4'b0111, 3);
      // counter sits past the new last column here
      run_directed(MODE_HPAIR, 12'd2, 13'd1, 4'b1110, 4);

      mode_now = MODE_HPAIR;
      width_now = 2;
      wide_now = 1'b0;
      while (random_items < RANDOM_ITEMS) begin
         calm = (random_items >= RANDOM_ITEMS * 4 / 5);
         quiet = ($urandom_range(0, 4) == 0);
         m = MODE_W'($urandom_range(0, 3));
         case ($urandom_range(0, 19))
            0, 1:    w = 12'd1;
            2:       w = 12'd0;
            3:       w = 12'd2048;
            4:       w = FW_W'($urandom);
            5, 6, 7: w = FW_W'($urandom_range(9, 40));
            default: w = FW_W'($urandom_range(2, 8));
         endcase
         case ($urandom_range(0, 19))
            0:       h = 13'd0;
            1, 2:    h = 13'd1;
            3:       h = 13'd4096;
            4:       h = 13'd8191;
            5:       h = FH_W'($urandom);
            default: h = FH_W'($urandom_range(2, 6));
         endcase
         sel = 4'($urandom_range(1, 15));
         if (sel[1])
            width_now = (w == '0) ? 1 :
                        ((int'(w) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(w));
         wide_prev = wide_now;
         wide_now = (width_now > FILL_COLS);
         if (sel[0]) mode_now = m;
         if ((wide_now || wide_prev) && mode_now != MODE_HPAIR) begin
            m = MODE_HPAIR;
            sel[0] = 1'b1;
            mode_now = MODE_HPAIR;
         end
         settle();
         set_regs(m, w, h, sel);
         n = $urandom_range(8, 90);
         repeat (n) send_random();
         random_items += n;
      end

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

>>> files.f
rtl/core/chss_pkg.sv
rtl/core/chss_pos.sv
rtl/core/chss_line.sv
rtl/core/chroma_subsample_replicate.sv
tb/chroma_check.sv
tb/tb.sv
